// ===== rtl/tlrq_pkg.sv =====
// ----------------------------------------------------------------------------
// tlrq_pkg
// Types, codes and helpers shared by the three-level ready queue scheduler.
// ----------------------------------------------------------------------------
package tlrq_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_PICK   = 2'd1,
    CMD_AGE    = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    PH_PICK = 2'd0,
    PH_AGE  = 2'd1,
    PH_REQ  = 2'd2
  } phase_t;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_L1_FLOOR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_L2_FLOOR   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAIT_INC   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WAIT_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PRIO_STEP  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PRIO_MAX   = 3'd5;

  localparam logic [7:0]  L1_FLOOR_RST   = 8'd100;
  localparam logic [7:0]  L2_FLOOR_RST   = 8'd50;
  localparam logic [9:0]  WAIT_INC_RST   = 10'd100;
  localparam logic [15:0] WAIT_LIMIT_RST = 16'd400;
  localparam logic [7:0]  PRIO_STEP_RST  = 8'd10;
  localparam logic [7:0]  PRIO_MAX_RST   = 8'd149;

  localparam logic [16:0] WAIT_SAT  = 17'h1FFFF;
  localparam logic [4:0]  COUNT_SAT = 5'd31;

  localparam logic [1:0] LVL_NONE = 2'd0;
  localparam logic [1:0] LVL_1    = 2'd1;
  localparam logic [1:0] LVL_2    = 2'd2;
  localparam logic [1:0] LVL_3    = 2'd3;

  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  prio;
    logic [15:0] burst;
    logic [16:0] wait_cnt;
    logic [31:0] order;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS,
    S_SCAN,
    S_FLUSH,
    S_PICK_END,
    S_REQ_START,
    S_REQ_SCAN,
    S_REQ_FLUSH,
    S_REQ_COMMIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic    load;
    logic    ins_step;
    logic    rd;
    phase_t  phase;
    logic    req_clr;
    logic    req_commit;
    logic    pick_commit;
    logic    res_load;
    status_t res_code;
  } dp_cmd_t;

  typedef struct packed {
    logic ins_free;
    logic idx_last;
    logic found;
    logic any_pending;
    logic out_free;
  } dp_status_t;

  function automatic logic [1:0] level_of(input logic [7:0] prio,
                                          input logic [7:0] l1_floor,
                                          input logic [7:0] l2_floor);
    logic [1:0] lvl;
    if (prio >= l1_floor) begin
      lvl = LVL_1;
    end else if (prio >= l2_floor) begin
      lvl = LVL_2;
    end else begin
      lvl = LVL_3;
    end
    return lvl;
  endfunction

endpackage

// ===== rtl/tlrq_req_if.sv =====
// ----------------------------------------------------------------------------
// tlrq_req_if
// Command channel of the scheduler: valid, ready and one command item.
// ----------------------------------------------------------------------------
interface tlrq_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] thread_id;
  logic [7:0]  priority_req;
  logic [15:0] burst_time;

  modport source (output valid, cmd, thread_id, priority_req, burst_time, input ready);
  modport sink (input valid, cmd, thread_id, priority_req, burst_time, output ready);
endinterface

// ===== rtl/tlrq_rsp_if.sv =====
// ----------------------------------------------------------------------------
// tlrq_rsp_if
// Result channel of the scheduler: valid, ready and one result item.
// ----------------------------------------------------------------------------
interface tlrq_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] picked_id;
  logic [1:0]  picked_level;
  logic [7:0]  picked_priority;
  logic [15:0] picked_burst;
  logic [4:0]  aged_count;

  modport source (output valid, status, picked_id, picked_level, picked_priority,
                  picked_burst, aged_count, input ready);
  modport sink (input valid, status, picked_id, picked_level, picked_priority,
                picked_burst, aged_count, output ready);
endinterface

// ===== rtl/tlrq_cfg_if.sv =====
// ----------------------------------------------------------------------------
// tlrq_cfg_if
// Register write channel of the scheduler: valid, ready, index and data.
// ----------------------------------------------------------------------------
interface tlrq_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/tlrq_ram.sv =====
// ----------------------------------------------------------------------------
// tlrq_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module tlrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/tlrq_ctrl.sv =====
// ----------------------------------------------------------------------------
// tlrq_ctrl
// Sequencer: walks the table for insert, pick, aging and requeue passes.
// ----------------------------------------------------------------------------
module tlrq_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  tlrq_pkg::cmd_t       in_cmd,
  output logic                 in_ready,
  input  tlrq_pkg::dp_status_t sts,
  output tlrq_pkg::dp_cmd_t    ctl
);

  tlrq_pkg::state_t  state, state_next;
  tlrq_pkg::status_t code, code_next;
  logic              is_age, is_age_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= tlrq_pkg::S_IDLE;
      code   <= tlrq_pkg::ST_OK;
      is_age <= 1'b0;
    end else begin
      state  <= state_next;
      code   <= code_next;
      is_age <= is_age_next;
    end
  end

  always_comb begin
    state_next  = state;
    code_next   = code;
    is_age_next = is_age;
    unique case (state)
      tlrq_pkg::S_IDLE: begin
        if (in_valid) begin
          is_age_next = (in_cmd == tlrq_pkg::CMD_AGE);
          code_next   = tlrq_pkg::ST_OK;
          unique case (in_cmd)
            tlrq_pkg::CMD_INSERT: state_next = tlrq_pkg::S_INS;
            tlrq_pkg::CMD_PICK, tlrq_pkg::CMD_AGE: state_next = tlrq_pkg::S_SCAN;
            default: state_next = tlrq_pkg::S_DONE;
          endcase
        end
      end
      tlrq_pkg::S_INS: begin
        if (sts.ins_free) begin
          state_next = tlrq_pkg::S_DONE;
        end else if (sts.idx_last) begin
          code_next  = tlrq_pkg::ST_FULL;
          state_next = tlrq_pkg::S_DONE;
        end
      end
      tlrq_pkg::S_SCAN: begin
        if (sts.idx_last) state_next = tlrq_pkg::S_FLUSH;
      end
      tlrq_pkg::S_FLUSH: begin
        state_next = is_age ? tlrq_pkg::S_REQ_START : tlrq_pkg::S_PICK_END;
      end
      tlrq_pkg::S_PICK_END: begin
        code_next  = sts.found ? tlrq_pkg::ST_OK : tlrq_pkg::ST_EMPTY;
        state_next = tlrq_pkg::S_DONE;
      end
      tlrq_pkg::S_REQ_START: begin
        state_next = sts.any_pending ? tlrq_pkg::S_REQ_SCAN : tlrq_pkg::S_DONE;
      end
      tlrq_pkg::S_REQ_SCAN: begin
        if (sts.idx_last) state_next = tlrq_pkg::S_REQ_FLUSH;
      end
      tlrq_pkg::S_REQ_FLUSH: state_next = tlrq_pkg::S_REQ_COMMIT;
      tlrq_pkg::S_REQ_COMMIT: state_next = tlrq_pkg::S_REQ_START;
      tlrq_pkg::S_DONE: begin
        if (sts.out_free) state_next = tlrq_pkg::S_IDLE;
      end
      default: state_next = tlrq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    ctl      = '0;
    ctl.res_code = code;
    unique case (state)
      tlrq_pkg::S_IDLE: begin
        in_ready = 1'b1;
        ctl.load = in_valid;
      end
      tlrq_pkg::S_INS: ctl.ins_step = 1'b1;
      tlrq_pkg::S_SCAN: begin
        ctl.rd    = 1'b1;
        ctl.phase = is_age ? tlrq_pkg::PH_AGE : tlrq_pkg::PH_PICK;
      end
      tlrq_pkg::S_PICK_END: ctl.pick_commit = sts.found;
      tlrq_pkg::S_REQ_START: ctl.req_clr = sts.any_pending;
      tlrq_pkg::S_REQ_SCAN: begin
        ctl.rd    = 1'b1;
        ctl.phase = tlrq_pkg::PH_REQ;
      end
      tlrq_pkg::S_REQ_COMMIT: ctl.req_commit = 1'b1;
      tlrq_pkg::S_DONE: ctl.res_load = sts.out_free;
      default: ;
    endcase
  end

endmodule

// ===== rtl/tlrq_dp.sv =====
// ----------------------------------------------------------------------------
// tlrq_dp
// Datapath: slot table, registers, scan compare stage and result register.
// ----------------------------------------------------------------------------
module tlrq_dp #(
  parameter int MAX_THREADS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  tlrq_pkg::dp_cmd_t    ctl,
  output tlrq_pkg::dp_status_t sts,
  input  logic [1:0]           in_cmd,
  input  logic [15:0]          in_thread_id,
  input  logic [7:0]           in_priority,
  input  logic [15:0]          in_burst,
  tlrq_rsp_if.source           rsp,
  tlrq_cfg_if.sink             cfg
);

  localparam int IW = $clog2(MAX_THREADS);
  localparam int EW = $bits(tlrq_pkg::entry_t);

  logic [7:0]  l1_floor, l2_floor, prio_step, prio_max;
  logic [9:0]  wait_inc;
  logic [15:0] wait_limit;

  logic [MAX_THREADS-1:0] valid, pending;
  logic [31:0]            counter, c0;
  logic [IW-1:0]          idx, rd_idx, best_idx;
  logic                   rd_pend;
  tlrq_pkg::phase_t       rd_phase;
  tlrq_pkg::entry_t       best_e, e, wr_e;
  logic [1:0]             best_lvl, lvl_c;
  logic                   best_found;
  logic [4:0]             aged_cnt;
  tlrq_pkg::cmd_t         item_cmd;
  logic [15:0]            item_id, item_burst;
  logic [7:0]             item_prio;

  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [EW-1:0] rd_word;

  logic [31:0] age_c, age_b, oage_c, oage_b;
  logic        beats, pick_take, req_take, age_hit, age_over;
  logic [17:0] wsum;
  logic [16:0] wsat;
  logic [8:0]  psum;
  logic [7:0]  np;

  logic        out_valid;

  tlrq_ram #(.WIDTH(EW), .DEPTH(MAX_THREADS)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_e),
    .rd_addr (idx),
    .rd_data (rd_word)
  );

  assign e     = tlrq_pkg::entry_t'(rd_word);
  assign lvl_c = tlrq_pkg::level_of(e.prio, l1_floor, l2_floor);
  assign age_c = counter - e.order;
  assign age_b = counter - best_e.order;
  assign oage_c = c0 - e.order;
  assign oage_b = c0 - best_e.order;

  always_comb begin
    if (lvl_c == tlrq_pkg::LVL_1 && e.burst != best_e.burst) begin
      beats = e.burst < best_e.burst;
    end else if (lvl_c == tlrq_pkg::LVL_2 && e.id != best_e.id) begin
      beats = e.id < best_e.id;
    end else begin
      beats = age_c > age_b;
    end
  end

  assign pick_take = rd_pend && rd_phase == tlrq_pkg::PH_PICK && valid[rd_idx] &&
                     (!best_found || lvl_c < best_lvl || (lvl_c == best_lvl && beats));
  assign req_take  = rd_pend && rd_phase == tlrq_pkg::PH_REQ && pending[rd_idx] &&
                     (!best_found || oage_c > oage_b);
  assign age_hit   = rd_pend && rd_phase == tlrq_pkg::PH_AGE && valid[rd_idx];

  assign wsum     = {1'b0, e.wait_cnt} + {8'b0, wait_inc};
  assign wsat     = wsum[17] ? tlrq_pkg::WAIT_SAT : wsum[16:0];
  assign age_over = wsat > {1'b0, wait_limit};
  assign psum     = {1'b0, e.prio} + {1'b0, prio_step};
  assign np       = (psum > {1'b0, prio_max}) ? prio_max : psum[7:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx;
    wr_e    = e;
    if (ctl.ins_step && !valid[idx]) begin
      wr_en   = 1'b1;
      wr_e    = '{id: item_id, prio: item_prio, burst: item_burst,
                  wait_cnt: 17'd0, order: counter};
    end else if (age_hit) begin
      wr_en   = 1'b1;
      wr_addr = rd_idx;
      if (age_over) begin
        wr_e.prio     = np;
        wr_e.wait_cnt = 17'd0;
      end else begin
        wr_e.wait_cnt = wsat;
      end
    end else if (ctl.req_commit) begin
      wr_en       = 1'b1;
      wr_addr     = best_idx;
      wr_e        = best_e;
      wr_e.order  = counter;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      l1_floor   <= tlrq_pkg::L1_FLOOR_RST;
      l2_floor   <= tlrq_pkg::L2_FLOOR_RST;
      wait_inc   <= tlrq_pkg::WAIT_INC_RST;
      wait_limit <= tlrq_pkg::WAIT_LIMIT_RST;
      prio_step  <= tlrq_pkg::PRIO_STEP_RST;
      prio_max   <= tlrq_pkg::PRIO_MAX_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        tlrq_pkg::REG_L1_FLOOR:   l1_floor   <= cfg.data[7:0];
        tlrq_pkg::REG_L2_FLOOR:   l2_floor   <= cfg.data[7:0];
        tlrq_pkg::REG_WAIT_INC:   wait_inc   <= cfg.data[9:0];
        tlrq_pkg::REG_WAIT_LIMIT: wait_limit <= cfg.data;
        tlrq_pkg::REG_PRIO_STEP:  prio_step  <= cfg.data[7:0];
        tlrq_pkg::REG_PRIO_MAX:   prio_max   <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      item_cmd   <= tlrq_pkg::cmd_t'(in_cmd);
      item_id    <= in_thread_id;
      item_prio  <= in_priority;
      item_burst <= in_burst;
      c0         <= counter;
    end
    if (pick_take || req_take) begin
      best_e   <= e;
      best_idx <= rd_idx;
      best_lvl <= lvl_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      pending    <= '0;
      counter    <= '0;
      idx        <= '0;
      rd_pend    <= 1'b0;
      rd_phase   <= tlrq_pkg::PH_PICK;
      rd_idx     <= '0;
      best_found <= 1'b0;
      aged_cnt   <= '0;
    end else begin
      rd_pend  <= ctl.rd;
      rd_phase <= ctl.phase;
      rd_idx   <= idx;
      if (ctl.load || ctl.req_clr) begin
        idx        <= '0;
        best_found <= 1'b0;
      end
      if (ctl.load) aged_cnt <= '0;
      if (ctl.rd) idx <= (idx == IW'(MAX_THREADS - 1)) ? '0 : idx + 1'b1;
      if (ctl.ins_step) begin
        if (!valid[idx]) begin
          valid[idx] <= 1'b1;
          counter    <= counter + 32'd1;
        end else if (idx != IW'(MAX_THREADS - 1)) begin
          idx <= idx + 1'b1;
        end
      end
      if (pick_take || req_take) best_found <= 1'b1;
      if (age_hit && age_over) begin
        pending[rd_idx] <= 1'b1;
        if (aged_cnt != tlrq_pkg::COUNT_SAT) aged_cnt <= aged_cnt + 5'd1;
      end
      if (ctl.req_commit) begin
        pending[best_idx] <= 1'b0;
        counter           <= counter + 32'd1;
      end
      if (ctl.pick_commit) valid[best_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.res_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.res_load) begin
      rsp.status          <= ctl.res_code;
      rsp.picked_id       <= '0;
      rsp.picked_level    <= tlrq_pkg::LVL_NONE;
      rsp.picked_priority <= '0;
      rsp.picked_burst    <= '0;
      rsp.aged_count      <= '0;
      if (item_cmd == tlrq_pkg::CMD_PICK && ctl.res_code == tlrq_pkg::ST_OK) begin
        rsp.picked_id       <= best_e.id;
        rsp.picked_level    <= best_lvl;
        rsp.picked_priority <= best_e.prio;
        rsp.picked_burst    <= best_e.burst;
      end
      if (item_cmd == tlrq_pkg::CMD_AGE) rsp.aged_count <= aged_cnt;
    end
  end

  assign rsp.valid = out_valid;

  assign sts.ins_free    = !valid[idx];
  assign sts.idx_last    = (idx == IW'(MAX_THREADS - 1));
  assign sts.found       = best_found;
  assign sts.any_pending = |pending;
  assign sts.out_free    = !out_valid || rsp.ready;

  a_pending_valid: assert property (@(posedge clk) disable iff (rst)
    (pending & ~valid) == '0)
    else $error("aging mark on an empty slot");

  a_pick_clears: assert property (@(posedge clk) disable iff (rst)
    ctl.pick_commit |=> !valid[$past(best_idx)])
    else $error("picked slot still valid");

  a_commit_found: assert property (@(posedge clk) disable iff (rst)
    ctl.req_commit |-> best_found)
    else $error("requeue commit without a selected entry");

  a_res_room: assert property (@(posedge clk) disable iff (rst)
    ctl.res_load |-> (!out_valid || rsp.ready))
    else $error("result register overwritten");

endmodule

// ===== rtl/three_level_ready_queue_scheduler.sv =====
// ----------------------------------------------------------------------------
// three_level_ready_queue_scheduler
// Three-level ready queue with shortest-burst, lowest-id and oldest-first
// levels and priority aging.
// ----------------------------------------------------------------------------
// One transaction is handled at a time, one table slot per cycle through a
// single-port-read table RAM. An insert walks up from slot 0 to the lowest
// free slot, or reports full at the last slot; a pick scans every slot once;
// an aging tick scans every slot once, then makes one more full pass per
// raised entry, each pass finding the oldest one still to requeue. An unused
// command goes straight to the result. A final state loads the result
// register; the next command is accepted while that result waits. No
// clearing pass follows reset.
module three_level_ready_queue_scheduler #(
  parameter int MAX_THREADS = 16
) (
  input  logic       clk,
  input  logic       rst,
  tlrq_req_if.sink   req,
  tlrq_rsp_if.source rsp,
  tlrq_cfg_if.sink   cfg
);

  tlrq_pkg::dp_cmd_t    ctl;
  tlrq_pkg::dp_status_t sts;
  logic                 in_ready;

  assign req.ready = in_ready;

  tlrq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_cmd   (tlrq_pkg::cmd_t'(req.cmd)),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  tlrq_dp #(.MAX_THREADS(MAX_THREADS)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .sts          (sts),
    .in_cmd       (req.cmd),
    .in_thread_id (req.thread_id),
    .in_priority  (req.priority_req),
    .in_burst     (req.burst_time),
    .rsp          (rsp),
    .cfg          (cfg)
  );

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the three-level ready queue scheduler: a directed
// table of commands followed by mixed random traffic under several register
// settings, with random gaps on both channels, a long result hold-off, and a
// scoreboard fed by a behavioral table model.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int NSLOT = 16;
  localparam int DRAIN_CYCLES = 2000;
  localparam int WATCHDOG_LIMIT = 100000;

  typedef struct packed {
    tlrq_pkg::status_t status;
    logic [15:0] id;
    logic [1:0]  level;
    logic [7:0]  prio;
    logic [15:0] burst;
    logic [4:0]  aged;
  } sched_result_t;

  typedef struct {
    tlrq_pkg::cmd_t cmd;
    logic [15:0] id;
    logic [7:0]  prio;
    logic [15:0] burst;
    logic        typed;
    sched_result_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tlrq_req_if req();
  tlrq_rsp_if rsp();
  tlrq_cfg_if cfg();

  three_level_ready_queue_scheduler #(.MAX_THREADS(NSLOT)) uut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source), .cfg(cfg.sink)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // table model state
  logic [7:0]  m_l1_floor, m_l2_floor, m_prio_step, m_prio_max;
  logic [9:0]  m_wait_inc;
  logic [15:0] m_wait_limit;
  logic        m_valid [NSLOT];
  logic [15:0] m_id    [NSLOT];
  logic [7:0]  m_prio  [NSLOT];
  logic [15:0] m_burst [NSLOT];
  logic [16:0] m_wait  [NSLOT];
  logic [31:0] m_order [NSLOT];
  logic [31:0] m_counter;

  sched_result_t expected_results[$];
  int errors = 0;
  int accepted = 0;
  int results_seen = 0;
  int n_full = 0, n_empty = 0, n_aged = 0;
  int idle_cycles = 0;
  bit hold_off = 1'b0;

  function automatic logic [1:0] lvl_of(logic [7:0] p);
    if (p >= m_l1_floor) return tlrq_pkg::LVL_1;
    if (p >= m_l2_floor) return tlrq_pkg::LVL_2;
    return tlrq_pkg::LVL_3;
  endfunction

  function automatic bit wins(int a, int b, logic [1:0] lvl);
    logic [31:0] age_a, age_b;
    age_a = m_counter - m_order[a];
    age_b = m_counter - m_order[b];
    if (lvl == tlrq_pkg::LVL_1 && m_burst[a] != m_burst[b]) return m_burst[a] < m_burst[b];
    if (lvl == tlrq_pkg::LVL_2 && m_id[a] != m_id[b]) return m_id[a] < m_id[b];
    return age_a > age_b;
  endfunction

  function automatic sched_result_t schedule(tlrq_pkg::cmd_t c, logic [15:0] id,
                                             logic [7:0] p, logic [15:0] b);
    sched_result_t r;
    int sel;
    logic [1:0] best_lvl, l;
    logic [31:0] old_age [NSLOT];
    bit pend [NSLOT];
    logic [17:0] w;
    logic [8:0] np;
    int cnt;
    r = '0;
    r.status = tlrq_pkg::ST_OK;
    sel = -1;
    cnt = 0;
    case (c)
      tlrq_pkg::CMD_INSERT: begin
        for (int i = 0; i < NSLOT; i++) begin
          if (sel < 0 && !m_valid[i]) sel = i;
        end
        if (sel < 0) begin
          r.status = tlrq_pkg::ST_FULL;
        end else begin
          m_valid[sel] = 1'b1; m_id[sel] = id; m_prio[sel] = p; m_burst[sel] = b;
          m_wait[sel] = '0; m_order[sel] = m_counter; m_counter++;
        end
      end
      tlrq_pkg::CMD_PICK: begin
        best_lvl = 2'd0;
        for (int i = 0; i < NSLOT; i++) begin
          if (m_valid[i]) begin
            l = lvl_of(m_prio[i]);
            if (sel < 0 || l < best_lvl || (l == best_lvl && wins(i, sel, l))) begin
              sel = i; best_lvl = l;
            end
          end
        end
        if (sel < 0) begin
          r.status = tlrq_pkg::ST_EMPTY;
        end else begin
          m_valid[sel] = 1'b0;
          r.id = m_id[sel]; r.level = best_lvl; r.prio = m_prio[sel];
          r.burst = m_burst[sel];
        end
      end
      tlrq_pkg::CMD_AGE: begin
        for (int i = 0; i < NSLOT; i++) begin
          pend[i] = 1'b0;
          old_age[i] = m_counter - m_order[i];
          if (m_valid[i]) begin
            w = m_wait[i] + m_wait_inc;
            if (w > tlrq_pkg::WAIT_SAT) w = tlrq_pkg::WAIT_SAT;
            m_wait[i] = w[16:0];
            if (w > m_wait_limit) begin
              np = m_prio[i] + m_prio_step;
              if (np > m_prio_max) np = m_prio_max;
              m_prio[i] = np[7:0]; m_wait[i] = '0; pend[i] = 1'b1; cnt++;
            end
          end
        end
        forever begin
          sel = -1;
          for (int i = 0; i < NSLOT; i++) begin
            if (pend[i] && (sel < 0 || old_age[i] > old_age[sel])) sel = i;
          end
          if (sel < 0) break;
          pend[sel] = 1'b0; m_order[sel] = m_counter; m_counter++;
        end
        r.aged = (cnt > 31) ? tlrq_pkg::COUNT_SAT : cnt[4:0];
      end
      default: ;
    endcase
    return r;
  endfunction

  // result side: random stalls, a long hold-off on request
  initial begin
    int gap;
    rsp.ready = 1'b0;
    @(posedge clk iff !rst);
    forever begin
      if (hold_off) begin
        rsp.ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      gap = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(2);
      if ($urandom_range(3) == 0) gap = 0;
      if (gap > 0) begin
        rsp.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    sched_result_t got, want;
    if (!rst && rsp.valid && rsp.ready) begin
      results_seen++;
      got = '{tlrq_pkg::status_t'(rsp.status), rsp.picked_id, rsp.picked_level,
              rsp.picked_priority, rsp.picked_burst, rsp.aged_count};
      if (expected_results.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d actual %0d", want.status, got.status); errors++;
        end
        if (got.id !== want.id) begin
          $error("picked_id: expected %0d actual %0d", want.id, got.id); errors++;
        end
        if (got.level !== want.level) begin
          $error("picked_level: expected %0d actual %0d", want.level, got.level); errors++;
        end
        if (got.prio !== want.prio) begin
          $error("picked_priority: expected %0d actual %0d", want.prio, got.prio); errors++;
        end
        if (got.burst !== want.burst) begin
          $error("picked_burst: expected %0d actual %0d", want.burst, got.burst); errors++;
        end
        if (got.aged !== want.aged) begin
          $error("aged_count: expected %0d actual %0d", want.aged, got.aged); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)
        || (cfg.valid && cfg.ready) || hold_off) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg.valid <= 1'b1; cfg.index <= idx; cfg.data <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    case (idx)
      tlrq_pkg::REG_L1_FLOOR:   m_l1_floor = val[7:0];
      tlrq_pkg::REG_L2_FLOOR:   m_l2_floor = val[7:0];
      tlrq_pkg::REG_WAIT_INC:   m_wait_inc = val[9:0];
      tlrq_pkg::REG_WAIT_LIMIT: m_wait_limit = val;
      tlrq_pkg::REG_PRIO_STEP:  m_prio_step = val[7:0];
      tlrq_pkg::REG_PRIO_MAX:   m_prio_max = val[7:0];
      default: ;
    endcase
  endtask

  task automatic settle();
    req.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  // send one command; typed rows carry their own expected result
  task automatic send_cmd(tlrq_pkg::cmd_t c, logic [15:0] id, logic [7:0] p,
                          logic [15:0] b, logic typed, sched_result_t want);
    sched_result_t r;
    int gap;
    gap = ($urandom_range(15) == 0) ? $urandom_range(30) : $urandom_range(1);
    if ($urandom_range(2) == 0) gap = 0;
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1; req.cmd <= c; req.thread_id <= id;
    req.priority_req <= p; req.burst_time <= b;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    r = schedule(c, id, p, b);
    expected_results.push_back(typed ? want : r);
    accepted++;
    if (r.status == tlrq_pkg::ST_FULL) n_full++;
    if (r.status == tlrq_pkg::ST_EMPTY) n_empty++;
    if (c == tlrq_pkg::CMD_AGE && r.aged != 0) n_aged++;
  endtask

  task automatic random_cmd(int fill_bias);
    tlrq_pkg::cmd_t c;
    int k;
    k = $urandom_range(99);
    if (k < fill_bias) c = tlrq_pkg::CMD_INSERT;
    else if (k < 85) c = tlrq_pkg::CMD_PICK;
    else if (k < 98) c = tlrq_pkg::CMD_AGE;
    else c = tlrq_pkg::CMD_NONE;
    send_cmd(c, ($urandom_range(3) == 0) ? 16'($urandom_range(7)) : 16'($urandom),
             8'($urandom), ($urandom_range(3) == 0) ? 16'($urandom_range(3)) : 16'($urandom),
             1'b0, '0);
  endtask

  sched_result_t r_ok, r_full, r_empty;
  stim_row_t rows[$];

  initial begin
    req.valid = 1'b0; req.cmd = tlrq_pkg::CMD_NONE; req.thread_id = '0;
    req.priority_req = '0; req.burst_time = '0;
    cfg.valid = 1'b0; cfg.index = tlrq_pkg::REG_L1_FLOOR; cfg.data = '0;
    m_l1_floor = tlrq_pkg::L1_FLOOR_RST; m_l2_floor = tlrq_pkg::L2_FLOOR_RST;
    m_wait_inc = tlrq_pkg::WAIT_INC_RST; m_wait_limit = tlrq_pkg::WAIT_LIMIT_RST;
    m_prio_step = tlrq_pkg::PRIO_STEP_RST; m_prio_max = tlrq_pkg::PRIO_MAX_RST;
    for (int i = 0; i < NSLOT; i++) begin
      m_valid[i] = 1'b0; m_id[i] = '0; m_prio[i] = '0; m_burst[i] = '0;
      m_wait[i] = '0; m_order[i] = '0;
    end
    m_counter = '0;
    r_ok = '0; r_ok.status = tlrq_pkg::ST_OK;
    r_full = '0; r_full.status = tlrq_pkg::ST_FULL;
    r_empty = '0; r_empty.status = tlrq_pkg::ST_EMPTY;

    rows.push_back('{tlrq_pkg::CMD_PICK, 16'd0, 8'd0, 16'd0, 1'b1, r_empty});
    rows.push_back('{tlrq_pkg::CMD_AGE, 16'd0, 8'd0, 16'd0, 1'b1, r_ok});
    rows.push_back('{tlrq_pkg::CMD_NONE, 16'hFFFF, 8'hFF, 16'hFFFF, 1'b1, r_ok});
    rows.push_back('{tlrq_pkg::CMD_INSERT, 16'hFFFF, 8'hFF, 16'hFFFF, 1'b1, r_ok});
    rows.push_back('{tlrq_pkg::CMD_INSERT, 16'h0000, 8'h00, 16'h0000, 1'b1, r_ok});
    rows.push_back('{tlrq_pkg::CMD_INSERT, 16'h0005, 8'd60, 16'h0010, 1'b0, r_ok});
    rows.push_back('{tlrq_pkg::CMD_INSERT, 16'h0003, 8'd70, 16'h0010, 1'b0, r_ok});
    rows.push_back('{tlrq_pkg::CMD_INSERT, 16'h0009, 8'd120, 16'hFFFF, 1'b0, r_ok});
    for (int i = 0; i < 11; i++)
      rows.push_back('{tlrq_pkg::CMD_INSERT, 16'(i * 4099), 8'(i * 23), 16'(i * 5000),
                       1'b0, r_ok});
    rows.push_back('{tlrq_pkg::CMD_INSERT, 16'h1234, 8'd200, 16'd1, 1'b1, r_full});
    for (int i = 0; i < 6; i++)
      rows.push_back('{tlrq_pkg::CMD_AGE, 16'd0, 8'd0, 16'd0, 1'b0, r_ok});
    for (int i = 0; i < 5; i++)
      rows.push_back('{tlrq_pkg::CMD_PICK, 16'd0, 8'd0, 16'd0, 1'b0, r_ok});

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) send_cmd(rows[i].cmd, rows[i].id, rows[i].prio, rows[i].burst,
                               rows[i].typed, rows[i].want);

    // back-pressure: stall results while commands keep coming
    settle();
    hold_off = 1'b1;
    for (int i = 0; i < 20; i++) random_cmd(70);

    for (int ph = 0; ph < 6; ph++) begin
      settle();
      case (ph)
        0: begin
          write_reg(tlrq_pkg::REG_L1_FLOOR, 16'd255);
          write_reg(tlrq_pkg::REG_L2_FLOOR, 16'd0);
          write_reg(tlrq_pkg::REG_WAIT_INC, 16'd1023);
          write_reg(tlrq_pkg::REG_WAIT_LIMIT, 16'd0);
          write_reg(tlrq_pkg::REG_PRIO_STEP, 16'd255);
          write_reg(tlrq_pkg::REG_PRIO_MAX, 16'd255);
        end
        1: begin
          write_reg(tlrq_pkg::REG_L1_FLOOR, 16'd0);
          write_reg(tlrq_pkg::REG_L2_FLOOR, 16'd255);
          write_reg(tlrq_pkg::REG_WAIT_INC, 16'd0);
          write_reg(tlrq_pkg::REG_WAIT_LIMIT, 16'hFFFF);
          write_reg(tlrq_pkg::REG_PRIO_STEP, 16'd0);
          write_reg(tlrq_pkg::REG_PRIO_MAX, 16'd0);
        end
        2: begin
          write_reg(tlrq_pkg::REG_L1_FLOOR, 16'd50);
          write_reg(tlrq_pkg::REG_L2_FLOOR, 16'd150);
          write_reg(tlrq_pkg::REG_WAIT_INC, 16'd1023);
          write_reg(tlrq_pkg::REG_WAIT_LIMIT, 16'hFFFF);
          write_reg(tlrq_pkg::REG_PRIO_STEP, 16'd7);
          write_reg(tlrq_pkg::REG_PRIO_MAX, 16'd40);
        end
        default: begin
          write_reg(tlrq_pkg::REG_L1_FLOOR, 16'($urandom_range(255)));
          write_reg(tlrq_pkg::REG_L2_FLOOR, 16'($urandom_range(255)));
          write_reg(tlrq_pkg::REG_WAIT_INC, 16'($urandom_range(1023)));
          write_reg(tlrq_pkg::REG_WAIT_LIMIT, 16'($urandom_range(2000)));
          write_reg(tlrq_pkg::REG_PRIO_STEP, 16'($urandom_range(255)));
          write_reg(tlrq_pkg::REG_PRIO_MAX, 16'($urandom_range(255)));
        end
      endcase
      for (int i = 0; i < 270; i++) random_cmd((i % 90 < 45) ? 65 : 35);
    end

    req.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("covered %0d commands, %0d results: %0d full, %0d empty, %0d aging raises",
             accepted, results_seen, n_full, n_empty, n_aged);
    $display("register settings: reset, both extremes and four mixed sets");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
